/* hdl/huffman_tree_bit_decoder_defines.svh */
// Assertion macros shared by the Huffman tree bit decoder RTL
`ifndef HUFFMAN_TREE_BIT_DECODER_DEFINES_SVH
`define HUFFMAN_TREE_BIT_DECODER_DEFINES_SVH

// property must hold on every clock edge outside reset
`define HTBD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// condition must never be seen outside reset
`define HTBD_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

/* hdl/htbd_pkg.sv */
// Types and constants shared by the Huffman tree bit decoder
package htbd_pkg;

  localparam int unsigned NodeCount   = 512;
  localparam int unsigned NodeIdxW    = 9;
  localparam int unsigned BitsPerByte = 8;
  localparam int unsigned BitIdxW     = $clog2(BitsPerByte);
  localparam int unsigned LenW        = 32;
  localparam int unsigned SymW        = 8;

  localparam logic [NodeIdxW:0] NodeLimit = (NodeIdxW + 1)'(NodeCount);

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_CODE = 1'b1
  } op_e;

  typedef struct packed {
    logic [NodeIdxW-1:0] left;
    logic [NodeIdxW-1:0] right;
    logic                leaf;
    logic [SymW-1:0]     sym;
  } node_t;

  typedef struct packed {
    logic                we;
    logic                re;
    logic [NodeIdxW-1:0] waddr;
    logic [NodeIdxW-1:0] raddr;
    node_t               wdata;
  } ram_req_t;

  typedef struct packed {
    logic            sym_vld;
    logic            flush;
    logic [SymW-1:0] sym;
    logic            stream_end;
  } emit_req_t;

endpackage

/* hdl/htbd_node_ram.sv */
// Tree node memory: one write and one registered read port
module htbd_node_ram (
  input  logic               clk_i,
  input  htbd_pkg::ram_req_t req_i,
  output htbd_pkg::node_t    rdata_o
);
  import htbd_pkg::*;

  node_t mem [NodeCount];
  node_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/htbd_emit.sv */
// Symbol hold stage and output register; marks the last symbol of each code byte
module htbd_emit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  htbd_pkg::emit_req_t           req_i,
  output logic                          ack_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [htbd_pkg::SymW-1:0]     symbol_o,
  output logic                          last_of_byte_o,
  output logic                          stream_end_o
);
  import htbd_pkg::*;

  logic            hold_vld_q, hold_vld_d;
  logic [SymW-1:0] hold_sym_q, hold_sym_d;
  logic            hold_end_q, hold_end_d;
  logic            out_vld_q, out_vld_d;
  logic [SymW-1:0] out_sym_q, out_sym_d;
  logic            out_last_q, out_last_d;
  logic            out_end_q, out_end_d;
  logic            out_free;
  logic            load_out;

  assign out_free = !out_vld_q || !out_stall_i;
  assign ack_o    = out_free;

  always_comb begin
    hold_vld_d = hold_vld_q;
    hold_sym_d = hold_sym_q;
    hold_end_d = hold_end_q;
    out_vld_d  = out_vld_q && out_stall_i;
    out_sym_d  = out_sym_q;
    out_last_d = out_last_q;
    out_end_d  = out_end_q;
    load_out   = 1'b0;
    if (out_free && req_i.sym_vld) begin
      load_out   = hold_vld_q;
      out_last_d = 1'b0;
      hold_vld_d = 1'b1;
      hold_sym_d = req_i.sym;
      hold_end_d = req_i.stream_end;
    end else if (out_free && req_i.flush) begin
      load_out   = hold_vld_q;
      out_last_d = 1'b1;
      hold_vld_d = 1'b0;
    end
    if (load_out) begin
      out_vld_d = 1'b1;
      out_sym_d = hold_sym_q;
      out_end_d = hold_end_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      hold_vld_q <= hold_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_sym_q <= hold_sym_d;
    hold_end_q <= hold_end_d;
    out_sym_q  <= out_sym_d;
    out_last_q <= out_last_d;
    out_end_q  <= out_end_d;
  end

  assign out_valid_o    = out_vld_q;
  assign symbol_o       = out_sym_q;
  assign last_of_byte_o = out_last_q;
  assign stream_end_o   = out_end_q;

endmodule

/* hdl/htbd_walker.sv */
// Tree walk sequencer: node loads, bit stepping, bit count and length register
`include "huffman_tree_bit_decoder_defines.svh"

module htbd_walker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              op_i,
  input  logic [htbd_pkg::NodeIdxW-1:0]     node_index_i,
  input  logic [htbd_pkg::NodeIdxW-1:0]     left_index_i,
  input  logic [htbd_pkg::NodeIdxW-1:0]     right_index_i,
  input  logic                              is_leaf_i,
  input  logic [htbd_pkg::SymW-1:0]         leaf_symbol_i,
  input  logic [htbd_pkg::BitsPerByte-1:0]  code_byte_i,
  input  logic                              cfg_valid_i,
  input  logic [htbd_pkg::LenW-1:0]         cfg_data_i,
  output htbd_pkg::ram_req_t                ram_o,
  input  htbd_pkg::node_t                   rdata_i,
  output htbd_pkg::emit_req_t               emit_o,
  input  logic                              ack_i
);
  import htbd_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_BIT   = 4'b0010,
    ST_FETCH = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_e;

  state_e                 state_q, state_d;
  logic [LenW-1:0]        bits_q, bits_d;
  logic [LenW-1:0]        len_q, len_d;
  logic [NodeIdxW-1:0]    cur_node_q, cur_node_d;
  logic [BitIdxW-1:0]     bit_idx_q, bit_idx_d;
  node_t                  node_q, node_d;
  node_t                  root_q, root_d;
  logic [NodeIdxW-1:0]    child_q, child_d;
  logic [BitsPerByte-1:0] byte_q, byte_d;

  node_t               load_node;
  logic                bit_val;
  logic [NodeIdxW-1:0] child;
  logic [LenW-1:0]     bits_inc;
  logic                advance;

  assign load_node = '{left: left_index_i, right: right_index_i,
                       leaf: is_leaf_i, sym: leaf_symbol_i};
  assign bit_val   = byte_q[BitsPerByte-1];
  assign child     = bit_val ? node_q.right : node_q.left;
  assign bits_inc  = bits_q + 1'b1;

  always_comb begin
    state_d    = state_q;
    bits_d     = bits_q;
    len_d      = len_q;
    cur_node_d = cur_node_q;
    bit_idx_d  = bit_idx_q;
    node_d     = node_q;
    root_d     = root_q;
    child_d    = child_q;
    byte_d     = byte_q;
    ram_o      = '0;
    emit_o     = '0;
    advance    = 1'b0;
    in_stall_o = (state_q != ST_IDLE);

    if (cfg_valid_i) begin
      len_d = cfg_data_i;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (op_i == OP_CODE) begin
            byte_d    = code_byte_i;
            bit_idx_d = '0;
            state_d   = ST_BIT;
          end else if ({1'b0, node_index_i} < NodeLimit) begin
            ram_o.we    = 1'b1;
            ram_o.waddr = node_index_i;
            ram_o.wdata = load_node;
            if (node_index_i == '0) begin
              root_d = load_node;
            end
            if (node_index_i == cur_node_q) begin
              node_d = load_node;
            end
          end
        end
      end
      ST_BIT: begin
        if (bits_q >= len_q) begin
          state_d = ST_FLUSH;
        end else if (node_q.leaf) begin
          emit_o.sym_vld    = 1'b1;
          emit_o.sym        = node_q.sym;
          emit_o.stream_end = (bits_inc == len_q);
          if (ack_i) begin
            bits_d     = bits_inc;
            cur_node_d = '0;
            node_d     = root_q;
            advance    = 1'b1;
          end
        end else if ({1'b0, child} >= NodeLimit) begin
          bits_d     = bits_inc;
          cur_node_d = '0;
          node_d     = root_q;
          advance    = 1'b1;
        end else begin
          ram_o.re    = 1'b1;
          ram_o.raddr = child;
          child_d     = child;
          state_d     = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (rdata_i.leaf) begin
          emit_o.sym_vld    = 1'b1;
          emit_o.sym        = rdata_i.sym;
          emit_o.stream_end = (bits_inc == len_q);
          if (ack_i) begin
            bits_d     = bits_inc;
            cur_node_d = '0;
            node_d     = root_q;
            advance    = 1'b1;
          end
        end else begin
          bits_d     = bits_inc;
          cur_node_d = child_q;
          node_d     = rdata_i;
          advance    = 1'b1;
        end
      end
      ST_FLUSH: begin
        emit_o.flush = 1'b1;
        if (ack_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (advance) begin
      byte_d    = byte_q << 1;
      bit_idx_d = bit_idx_q + 1'b1;
      state_d   = (bit_idx_q == BitIdxW'(BitsPerByte - 1)) ? ST_FLUSH : ST_BIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      bits_q     <= '0;
      len_q      <= '0;
      cur_node_q <= '0;
      bit_idx_q  <= '0;
    end else begin
      state_q    <= state_d;
      bits_q     <= bits_d;
      len_q      <= len_d;
      cur_node_q <= cur_node_d;
      bit_idx_q  <= bit_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q  <= node_d;
    root_q  <= root_d;
    child_q <= child_d;
    byte_q  <= byte_d;
  end

  `HTBD_ASSERT_NEVER(a_ram_rw_clash, ram_o.we && ram_o.re, "node read and write in one cycle")
  `HTBD_ASSERT(a_fetch_issued, (state_q == ST_FETCH && $past(state_q) != ST_FETCH) |-> $past(ram_o.re), "fetch without read")
  `HTBD_ASSERT(a_emit_in_stream, emit_o.sym_vld |-> (bits_q < len_q), "symbol past stream end")
  `HTBD_ASSERT(a_bits_step, (state_q != ST_IDLE) |=> (bits_q == $past(bits_q) || bits_q == $past(bits_q) + 32'd1), "bit count jumped")

endmodule

/* hdl/huffman_tree_bit_decoder.sv */
// Huffman tree bit decoder top level: node memory, walk sequencer, output stage
//
//  beat      | dir | handshake                 | payload
//  ----------+-----+---------------------------+---------------------------------------
//  input     | in  | in_valid_i / in_stall_o   | op, node and child indices, leaf, byte
//  result    | out | out_valid_o / out_stall_i | symbol, last_of_byte, stream_end
//  length    | in  | cfg_valid_i / cfg_ready_o | code_length_bits
//
// A load beat writes its node straight into node memory. A code byte is accepted and
// closed by a flush; a bit taken at a leaf needs no read, and a bit that steps to a child
// takes one node memory read. Bits past the length are not walked.
// The input stalls while a code byte is being walked; output stalls hold the walk when
// a symbol has to move on. Reset clears the walk to the root, the bit count and the
// length; node memory contents are kept and must be loaded before use.
module huffman_tree_bit_decoder (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              op_i,
  input  logic [htbd_pkg::NodeIdxW-1:0]     node_index_i,
  input  logic [htbd_pkg::NodeIdxW-1:0]     left_index_i,
  input  logic [htbd_pkg::NodeIdxW-1:0]     right_index_i,
  input  logic                              is_leaf_i,
  input  logic [htbd_pkg::SymW-1:0]         leaf_symbol_i,
  input  logic [htbd_pkg::BitsPerByte-1:0]  code_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [htbd_pkg::SymW-1:0]         symbol_o,
  output logic                              last_of_byte_o,
  output logic                              stream_end_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [htbd_pkg::LenW-1:0]         cfg_data_i
);
  import htbd_pkg::*;

  ram_req_t  ram_req;
  node_t     ram_rdata;
  emit_req_t emit_req;
  logic      emit_ack;

  assign cfg_ready_o = 1'b1;

  htbd_node_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  htbd_walker u_walker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .node_index_i  (node_index_i),
    .left_index_i  (left_index_i),
    .right_index_i (right_index_i),
    .is_leaf_i     (is_leaf_i),
    .leaf_symbol_i (leaf_symbol_i),
    .code_byte_i   (code_byte_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .ram_o         (ram_req),
    .rdata_i       (ram_rdata),
    .emit_o        (emit_req),
    .ack_i         (emit_ack)
  );

  htbd_emit u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (emit_req),
    .ack_o          (emit_ack),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .symbol_o       (symbol_o),
    .last_of_byte_o (last_of_byte_o),
    .stream_end_o   (stream_end_o)
  );

endmodule
